FILE: design/arabic_contextual_glyph_shaper_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the contextual glyph shaper
// Shared forms for concurrent checks, with and without reset gating.
// ---------------------------------------------------------------------------
`ifndef ARABIC_CONTEXTUAL_GLYPH_SHAPER_TOP_MACROS_SVH
`define ARABIC_CONTEXTUAL_GLYPH_SHAPER_TOP_MACROS_SVH

// check gated by the active-low reset
`define ACGS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// check that also holds while in reset
`define ACGS_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: design/acgs_pkg.sv
// ---------------------------------------------------------------------------
// acgs_pkg
// Letter table, join-breaker list and shared types for the glyph shaper.
// ---------------------------------------------------------------------------
package acgs_pkg;

  localparam int CpW          = 21;
  localparam int TableRows    = 45;
  localparam int LetterCount  = 45;
  localparam int RowsUsed     = (LetterCount < TableRows) ? LetterCount : TableRows;
  localparam int RowW         = 6;
  localparam int BreakerCount = 13;
  localparam int QDepth       = 4;
  localparam int QIdxW        = 2;
  localparam int QCntW        = 3;

  typedef enum logic [2:0] {
    FORM_BASE = 3'd0,
    FORM_ISO  = 3'd1,
    FORM_INI  = 3'd2,
    FORM_MED  = 3'd3,
    FORM_FIN  = 3'd4
  } form_e;

  // Persian Yeh forms and their Arabic replacements
  localparam logic [CpW-1:0] YehFaIso = 21'h0FBFC;
  localparam logic [CpW-1:0] YehFaIni = 21'h0FBFE;
  localparam logic [CpW-1:0] YehFaMed = 21'h0FBFF;
  localparam logic [CpW-1:0] YehFaFin = 21'h0FBFD;
  localparam logic [CpW-1:0] YehArIni = 21'h0FEF3;
  localparam logic [CpW-1:0] YehArMed = 21'h0FEF4;
  localparam logic [CpW-1:0] MaksIso  = 21'h0FEEF;
  localparam logic [CpW-1:0] MaksFin  = 21'h0FEF0;

  // columns: base, isolated, initial, medial, final
  localparam logic [CpW-1:0] Letters [TableRows][5] = '{
    '{21'h0623, 21'hFE83, 21'h0623, 21'hFE84, 21'hFE84},
    '{21'h0627, 21'hFE8D, 21'h0627, 21'hFE8E, 21'hFE8E},
    '{21'h0622, 21'hFE81, 21'h0622, 21'hFE82, 21'hFE82},
    '{21'h0621, 21'hFE80, 21'h0621, 21'h0621, 21'h0621},
    '{21'h0624, 21'hFE85, 21'h0624, 21'hFE86, 21'hFE86},
    '{21'h0625, 21'hFE87, 21'h0625, 21'hFE88, 21'hFE88},
    '{21'h0626, 21'hFE89, 21'hFE8B, 21'hFE8C, 21'hFE8A},
    '{21'h0628, 21'hFE8F, 21'hFE91, 21'hFE92, 21'hFE90},
    '{21'h067E, 21'hFB56, 21'hFB58, 21'hFB59, 21'hFB57},
    '{21'h062A, 21'hFE95, 21'hFE97, 21'hFE98, 21'hFE96},
    '{21'h0629, 21'hFE93, 21'h0629, 21'h0629, 21'hFE94},
    '{21'h062B, 21'hFE99, 21'hFE9B, 21'hFE9C, 21'hFE9A},
    '{21'h062C, 21'hFE9D, 21'hFE9F, 21'hFEA0, 21'hFE9E},
    '{21'h0686, 21'hFB7A, 21'hFB7C, 21'hFB7D, 21'hFB7B},
    '{21'h062D, 21'hFEA1, 21'hFEA3, 21'hFEA4, 21'hFEA2},
    '{21'h062E, 21'hFEA5, 21'hFEA7, 21'hFEA8, 21'hFEA6},
    '{21'h062F, 21'hFEA9, 21'h062F, 21'hFEAA, 21'hFEAA},
    '{21'h0630, 21'hFEAB, 21'h0630, 21'hFEAC, 21'hFEAC},
    '{21'h0631, 21'hFEAD, 21'h0631, 21'hFEAE, 21'hFEAE},
    '{21'h0632, 21'hFEAF, 21'h0632, 21'hFEB0, 21'hFEB0},
    '{21'h0698, 21'hFB8A, 21'h0698, 21'hFB8B, 21'hFB8B},
    '{21'h0633, 21'hFEB1, 21'hFEB3, 21'hFEB4, 21'hFEB2},
    '{21'h0634, 21'hFEB5, 21'hFEB7, 21'hFEB8, 21'hFEB6},
    '{21'h0635, 21'hFEB9, 21'hFEBB, 21'hFEBC, 21'hFEBA},
    '{21'h0636, 21'hFEBD, 21'hFEBF, 21'hFEC0, 21'hFEBE},
    '{21'h0637, 21'hFEC1, 21'hFEC3, 21'hFEC4, 21'hFEC2},
    '{21'h0638, 21'hFEC5, 21'hFEC7, 21'hFEC8, 21'hFEC6},
    '{21'h0639, 21'hFEC9, 21'hFECB, 21'hFECC, 21'hFECA},
    '{21'h063A, 21'hFECD, 21'hFECF, 21'hFED0, 21'hFECE},
    '{21'h0641, 21'hFED1, 21'hFED3, 21'hFED4, 21'hFED2},
    '{21'h0642, 21'hFED5, 21'hFED7, 21'hFED8, 21'hFED6},
    '{21'h06A9, 21'hFED9, 21'hFEDB, 21'hFEDC, 21'hFEDA},
    '{21'h0643, 21'hFED9, 21'hFEDB, 21'hFEDC, 21'hFEDA},
    '{21'h06AF, 21'hFB92, 21'hFB94, 21'hFB95, 21'hFB93},
    '{21'h0644, 21'hFEDD, 21'hFEDF, 21'hFEE0, 21'hFEDE},
    '{21'h0645, 21'hFEE1, 21'hFEE3, 21'hFEE4, 21'hFEE2},
    '{21'h0646, 21'hFEE5, 21'hFEE7, 21'hFEE8, 21'hFEE6},
    '{21'h0647, 21'hFEE9, 21'hFEEB, 21'hFEEC, 21'hFEEA},
    '{21'h0648, 21'hFEED, 21'hFEED, 21'hFEEE, 21'hFEEE},
    '{21'h06CC, 21'hFBFC, 21'hFBFE, 21'hFBFF, 21'hFBFD},
    '{21'h064A, 21'hFEF1, 21'hFEF3, 21'hFEF4, 21'hFEF2},
    '{21'h0649, 21'hFEEF, 21'h0649, 21'hFEF0, 21'hFEF0},
    '{21'h0640, 21'h0640, 21'h0640, 21'h0640, 21'h0640},
    '{21'hFEFB, 21'hFEFB, 21'hFEFB, 21'hFEFC, 21'hFEFC},
    '{21'hFEF7, 21'hFEF7, 21'hFEF7, 21'hFEF8, 21'hFEF8}
  };

  localparam logic [CpW-1:0] Breakers [BreakerCount] = '{
    21'h0623, 21'h0622, 21'h0627, 21'h0621, 21'h0624, 21'h0625, 21'h062F,
    21'h0630, 21'h0631, 21'h0632, 21'h0698, 21'h0648, 21'h0649
  };

  // one shaping job handed from front to back
  typedef struct packed {
    logic [CpW-1:0] cp;
    logic           prev_letter;
    logic           prev_breaks;
    logic           next_letter;
    logic           last;
  } job_t;

  // up to two jobs pushed per accepted word
  typedef struct packed {
    logic a_en;
    logic b_en;
    job_t a;
    job_t b;
  } push_t;

  typedef struct packed {
    logic           hit;
    logic [RowW-1:0] row;
  } row_hit_t;

  // first table row holding the code point in any column
  function automatic row_hit_t find_row(logic [CpW-1:0] cp);
    row_hit_t r;
    r.hit = 1'b0;
    r.row = '0;
    for (int i = RowsUsed - 1; i >= 0; i--) begin
      for (int f = 0; f < 5; f++) begin
        if (Letters[i][f] == cp) begin
          r.hit = 1'b1;
          r.row = RowW'(i);
        end
      end
    end
    return r;
  endfunction

  function automatic logic is_breaker(logic [CpW-1:0] cp);
    logic b;
    b = 1'b0;
    for (int i = 0; i < BreakerCount; i++) begin
      if (Breakers[i] == cp) b = 1'b1;
    end
    return b;
  endfunction

endpackage

FILE: design/acgs_front.sv
// ---------------------------------------------------------------------------
// acgs_front
// Accepts code points, classifies them and issues shaping jobs.
// ---------------------------------------------------------------------------
module acgs_front
  import acgs_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [CpW-1:0] code_point_i,
  input  logic           line_end_i,
  input  logic           space_i,
  output push_t          push_o
);

  logic [CpW-1:0] pend_cp_q, pend_cp_d;
  logic pend_valid_q, pend_valid_d;
  logic pend_letter_q, pend_letter_d;
  logic pend_brk_q, pend_brk_d;
  logic bil_q, bil_d;
  logic bbj_q, bbj_d;

  logic     accept;
  row_hit_t cls;
  logic     cur_brk;
  logic     bil_n, bbj_n;

  assign in_ready_o = space_i;
  assign accept     = in_valid_i && space_i;

  always_comb begin
    cls     = find_row(code_point_i);
    cur_brk = is_breaker(code_point_i);
    // neighbour state once the held character has gone out
    bil_n   = pend_valid_q ? pend_letter_q : bil_q;
    bbj_n   = pend_valid_q ? (pend_letter_q && pend_brk_q) : bbj_q;

    push_o.a = '{cp: pend_cp_q, prev_letter: bil_q, prev_breaks: bbj_q,
                 next_letter: cls.hit, last: !line_end_i};
    push_o.b = '{cp: code_point_i, prev_letter: bil_n, prev_breaks: bbj_n,
                 next_letter: 1'b0, last: 1'b1};
    push_o.a_en = accept && pend_valid_q;
    push_o.b_en = accept && line_end_i;

    pend_cp_d     = pend_cp_q;
    pend_valid_d  = pend_valid_q;
    pend_letter_d = pend_letter_q;
    pend_brk_d    = pend_brk_q;
    bil_d         = bil_q;
    bbj_d         = bbj_q;
    if (accept) begin
      if (line_end_i) begin
        pend_cp_d     = '0;
        pend_valid_d  = 1'b0;
        pend_letter_d = 1'b0;
        pend_brk_d    = 1'b0;
        bil_d         = 1'b0;
        bbj_d         = 1'b0;
      end else begin
        pend_cp_d     = code_point_i;
        pend_valid_d  = 1'b1;
        pend_letter_d = cls.hit;
        pend_brk_d    = cur_brk;
        bil_d         = bil_n;
        bbj_d         = bbj_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_cp_q     <= '0;
      pend_valid_q  <= 1'b0;
      pend_letter_q <= 1'b0;
      pend_brk_q    <= 1'b0;
      bil_q         <= 1'b0;
      bbj_q         <= 1'b0;
    end else begin
      pend_cp_q     <= pend_cp_d;
      pend_valid_q  <= pend_valid_d;
      pend_letter_q <= pend_letter_d;
      pend_brk_q    <= pend_brk_d;
      bil_q         <= bil_d;
      bbj_q         <= bbj_d;
    end
  end

endmodule

FILE: design/acgs_queue.sv
// ---------------------------------------------------------------------------
// acgs_queue
// Small job queue: two pushes, one pop per cycle.
// ---------------------------------------------------------------------------
module acgs_queue
  import acgs_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  space_o,
  output logic  nempty_o,
  output job_t  head_o,
  input  logic  pop_i
);

  job_t ent_q [QDepth];
  logic [QIdxW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic [QCntW-1:0] n_push;
  logic pop;

  assign space_o  = cnt_q <= QCntW'(QDepth - 2);
  assign nempty_o = cnt_q != '0;
  assign head_o   = ent_q[rd_q];
  assign pop      = pop_i && nempty_o;
  assign n_push   = QCntW'(push_i.a_en) + QCntW'(push_i.b_en);

  always_comb begin
    wr_d  = wr_q + QIdxW'(n_push);
    rd_d  = rd_q + QIdxW'(pop);
    cnt_d = cnt_q + n_push - QCntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.a_en) begin
      ent_q[wr_q] <= push_i.a;
      if (push_i.b_en) ent_q[wr_q + QIdxW'(1)] <= push_i.b;
    end else if (push_i.b_en) begin
      ent_q[wr_q] <= push_i.b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: design/acgs_back.sv
// ---------------------------------------------------------------------------
// acgs_back
// Picks the presentation form for a job and holds the result word.
// ---------------------------------------------------------------------------
module acgs_back
  import acgs_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  job_t           job_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [CpW-1:0] glyph_o,
  output logic           was_shaped_o,
  output logic           last_o
);

  logic           out_valid_q, out_valid_d;
  logic [CpW-1:0] glyph_q, glyph_d;
  logic           shaped_q, shaped_d;
  logic           last_q, last_d;
  row_hit_t       rh;
  form_e          form;
  logic [CpW-1:0] g;

  assign pop_o        = job_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o  = out_valid_q;
  assign glyph_o      = glyph_q;
  assign was_shaped_o = shaped_q;
  assign last_o       = last_q;

  always_comb begin
    rh = find_row(job_i.cp);
    if (job_i.prev_letter && job_i.next_letter && !job_i.prev_breaks) form = FORM_MED;
    else if (job_i.next_letter)                                     form = FORM_INI;
    else if (job_i.prev_letter && !job_i.prev_breaks)               form = FORM_FIN;
    else                                                            form = FORM_ISO;
    g = Letters[rh.row][form];
    // Persian Yeh goes to the Arabic Yeh / Alef Maksura forms
    unique case (form)
      FORM_MED: if (g == YehFaMed) g = YehArMed;
      FORM_INI: if (g == YehFaIni) g = YehArIni;
      FORM_FIN: if (g == YehFaFin) g = MaksFin;
      FORM_ISO: if (g == YehFaIso) g = MaksIso;
      default: ;
    endcase

    glyph_d     = glyph_q;
    shaped_d    = shaped_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (pop_o) begin
      glyph_d     = rh.hit ? g : job_i.cp;
      shaped_d    = rh.hit;
      last_d      = job_i.last;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else         out_valid_q <= out_valid_d;
  end

  always_ff @(posedge clk_i) begin
    glyph_q  <= glyph_d;
    shaped_q <= shaped_d;
    last_q   <= last_d;
  end

endmodule

FILE: design/arabic_contextual_glyph_shaper_top.sv
// A word is held until its successor arrives; on acceptance of the successor its job
// is queued, then taken into the output register; a line-end word's own result follows.
// Throughput: one word per cycle while the queue has room, one result per cycle while
// ready; a line-end word with a held character gives two results: output sets the rate.
// Reset (rst_ni low, asynchronous): nothing held, no previous letter, queue empty.
// ---------------------------------------------------------------------------
// arabic_contextual_glyph_shaper_top
// Contextual shaper for Arabic/Persian letters: front classifies and
// tracks neighbours, a four-entry job queue decouples it from the back,
// which looks up the presentation form and drives the result word.
// ---------------------------------------------------------------------------
module arabic_contextual_glyph_shaper_top
  import acgs_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [CpW-1:0] code_point_i,
  input  logic           line_end_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [CpW-1:0] glyph_o,
  output logic           was_shaped_o,
  output logic           last_o
);

  push_t push;
  logic  space, nempty, pop;
  job_t  head;

  // front: holds one character back and emits up to two jobs per word
  acgs_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .code_point_i, .line_end_i,
    .space_i (space),
    .push_o  (push)
  );

  // queue keeps room for two jobs before a word is taken
  acgs_queue u_queue (
    .clk_i, .rst_ni,
    .push_i   (push),
    .space_o  (space),
    .nempty_o (nempty),
    .head_o   (head),
    .pop_i    (pop)
  );

  // back: form selection into the output register
  acgs_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i (nempty),
    .job_i       (head),
    .pop_o       (pop),
    .out_valid_o, .out_ready_i, .glyph_o, .was_shaped_o, .last_o
  );

endmodule

FILE: design/acgs_checker.sv
// ---------------------------------------------------------------------------
// acgs_checker
// Port-level checks on the glyph shaper, bound to the top level.
// ---------------------------------------------------------------------------
`include "arabic_contextual_glyph_shaper_top_macros.svh"

module acgs_checker
  import acgs_pkg::*;
(
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input logic [CpW-1:0] glyph_o,
  input logic           was_shaped_o
);

  `ACGS_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o, "result word dropped while stalled")
  `ACGS_ASSERT(a_shaped_range, clk_i, rst_ni, out_valid_o && was_shaped_o |-> glyph_o >= 21'h0621 && glyph_o <= 21'hFEFC, "shaped glyph outside table range")
  `ACGS_ASSERT(a_no_fa_yeh, clk_i, rst_ni, out_valid_o && was_shaped_o |-> glyph_o != YehFaIso && glyph_o != YehFaIni && glyph_o != YehFaMed && glyph_o != YehFaFin, "Persian Yeh form not substituted")
  // the register is cleared asynchronously by reset, so valid is low after reset has been sampled
  `ACGS_ASSERT_NR(a_reset_idle, clk_i, !rst_ni |=> !out_valid_o, "result valid after a reset cycle")

endmodule

bind arabic_contextual_glyph_shaper_top acgs_checker u_acgs_checker (.*);

FILE: tb/arabic_contextual_glyph_shaper_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Contextual glyph shaper testbench
// Drives code points with random gaps against a local shaping model and
// compares every result word with the oldest predicted one.
// ---------------------------------------------------------------------------
module arabic_contextual_glyph_shaper_top_tb;
  import acgs_pkg::*;

  typedef struct {
    logic [CpW-1:0] glyph;
    logic           shaped;
    logic           last;
  } glyph_word_t;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid_i = 1'b0;
  logic           in_ready_o;
  logic [CpW-1:0] code_point_i = '0;
  logic           line_end_i = 1'b0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  logic [CpW-1:0] glyph_o;
  logic           was_shaped_o;
  logic           last_o;

  glyph_word_t    glyph_q[$];
  int             mismatches = 0;
  bit             calm = 1'b0;   // no idling in the last part of the run

  // shaper state, mirrors the block
  logic [CpW-1:0] held_cp = '0;
  logic           held_ok = 1'b0;
  logic           prior_letter = 1'b0;
  logic           prior_breaks = 1'b0;

  arabic_contextual_glyph_shaper_top DUT (.*);

  always #1 clk_i = ~clk_i;

  // letter table row of a code point, -1 if none; first row wins
  function automatic int letter_row(logic [CpW-1:0] cp);
    for (int r = 0; r < TableRows; r++)
      for (int c = 0; c < 5; c++)
        if (Letters[r][c] == cp) return r;
    return -1;
  endfunction

  function automatic bit joins_not_left(logic [CpW-1:0] cp);
    for (int k = 0; k < BreakerCount; k++)
      if (Breakers[k] == cp) return 1'b1;
    return 1'b0;
  endfunction

  function automatic glyph_word_t shape_glyph(logic [CpW-1:0] cp, bit pl, bit pb,
                                              bit nl, bit lst);
    glyph_word_t w;
    int r;
    r = letter_row(cp);
    w.last = lst;
    w.shaped = (r >= 0);
    w.glyph = cp;
    if (r >= 0) begin
      if (pl && nl && !pb) begin
        w.glyph = Letters[r][FORM_MED];
        if (w.glyph == YehFaMed) w.glyph = YehArMed;
      end else if (nl) begin
        w.glyph = Letters[r][FORM_INI];
        if (w.glyph == YehFaIni) w.glyph = YehArIni;
      end else if (pl && !pb) begin
        w.glyph = Letters[r][FORM_FIN];
        if (w.glyph == YehFaFin) w.glyph = MaksFin;
      end else begin
        w.glyph = Letters[r][FORM_ISO];
        if (w.glyph == YehFaIso) w.glyph = MaksIso;
      end
    end
    return w;
  endfunction

  // predicted words for one accepted character
  task automatic predict_glyphs(logic [CpW-1:0] cp, logic le);
    if (held_ok) begin
      glyph_q.push_back(shape_glyph(held_cp, prior_letter, prior_breaks,
                                    letter_row(cp) >= 0, !le));
      prior_letter = letter_row(held_cp) >= 0;
      prior_breaks = prior_letter && joins_not_left(held_cp);
    end
    if (le) begin
      glyph_q.push_back(shape_glyph(cp, prior_letter, prior_breaks, 1'b0, 1'b1));
      held_ok = 1'b0; prior_letter = 1'b0; prior_breaks = 1'b0;
    end else begin
      held_cp = cp; held_ok = 1'b1;
    end
  endtask

  // valid stays up after acceptance; a random gap in the next send or an idle drops it
  task automatic send_char(logic [CpW-1:0] cp, logic le);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    code_point_i <= cp;
    line_end_i <= le;
    do @(posedge clk_i); while (!in_ready_o);
    predict_glyphs(cp, le);
    @(negedge clk_i);
  endtask

  // drop valid and wait until every predicted word has come out
  task automatic idle_until_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (glyph_q.size() != 0);
  endtask

  // receiver stalls
  initial begin
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // result checker
  initial begin
    glyph_word_t w;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (glyph_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word glyph=%h", glyph_o);
        end else begin
          w = glyph_q.pop_front();
          if (w.glyph !== glyph_o || w.shaped !== was_shaped_o || w.last !== last_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp %h/%b/%b got %h/%b/%b", w.glyph, w.shaped,
                       w.last, glyph_o, was_shaped_o, last_o);
          end
        end
      end
    end
  end

  function automatic logic [CpW-1:0] any_letter();
    return Letters[$urandom_range(0, TableRows - 1)][$urandom_range(0, 4)];
  endfunction

  task automatic test_directed();
    send_char(21'h0628, 1'b1);            // lone letter at line end: isolated
    send_char(21'h0628, 1'b0);            // initial, medial, final
    send_char(21'h06CC, 1'b0);            // Persian Yeh medial
    send_char(21'h0628, 1'b1);
    send_char(21'h06CC, 1'b0);            // Yeh initial
    send_char(21'h0627, 1'b0);            // alef breaks the join
    send_char(21'h06CC, 1'b1);            // Yeh isolated after breaker
    send_char(21'h0628, 1'b0);
    send_char(21'h06CC, 1'b1);            // Yeh final
    send_char(21'hFE8D, 1'b0);            // presentation form as input
    send_char(21'h0628, 1'b0);
    send_char(21'h0020, 1'b0);            // space between letters
    send_char(21'h1FFFFF, 1'b0);          // above the Unicode range
    send_char(21'h000000, 1'b0);
    send_char(21'h0640, 1'b0);
    send_char(21'hFEFB, 1'b1);
    send_char(21'h0041, 1'b1);
  endtask

  task automatic test_random_lines(int n);
    logic [CpW-1:0] cp;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: cp = CpW'($urandom_range(0, 21'h1FFFFF));
        1: cp = CpW'($urandom_range(21'h0600, 21'h06FF));
        2: cp = 21'h0020;
        default: cp = any_letter();
      endcase
      send_char(cp, $urandom_range(0, 7) == 0);
    end
  endtask

  task automatic test_drain_pause();
    send_char(21'h0628, 1'b1);
    idle_until_drained();
    send_char(21'h0644, 1'b0);
    send_char(21'h0627, 1'b1);
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random_lines(500);
    test_drain_pause();
    test_random_lines(400);
    calm = 1'b1;
    test_random_lines(100);
    send_char(21'h0628, 1'b1);   // flush any held character
    idle_until_drained();
    repeat (20) @(negedge clk_i);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #200000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/acgs_pkg.sv
design/acgs_front.sv
design/acgs_queue.sv
design/acgs_back.sv
design/arabic_contextual_glyph_shaper_top.sv
design/acgs_checker.sv
tb/arabic_contextual_glyph_shaper_top_tb.sv
